### rtl/als_pkg.sv
// shared types, constants and helpers for the addressable LED serializer
// used by als_step and addressable_led_serializer; no dependencies
package als_pkg;

  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;
  localparam int BYTE_W = 8;
  localparam int BITS_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [BITS_W-1:0] BITS_PER_BYTE = BITS_W'(BYTE_W);

  localparam logic [IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LATCH     = 3'd4;
  localparam logic [IDX_W-1:0] REG_MSB_FIRST = 3'd5;

  localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 16'd5;
  localparam logic [CFG_W-1:0] ZERO_LOW_RST  = 16'd13;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 16'd18;
  localparam logic [CFG_W-1:0] ONE_LOW_RST   = 16'd1;
  localparam logic [CFG_W-1:0] LATCH_RST     = 16'd6400;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] zero_low;
    logic [CFG_W-1:0] one_high;
    logic [CFG_W-1:0] one_low;
    logic [CFG_W-1:0] latch;
    logic             msb_first;
  } timing_cfg_t;

  typedef struct packed {
    logic line_level;
    logic byte_taken;
    logic busy_res;
  } tick_res_t;

  // zero counts as one tick, oversize values saturate
  function automatic logic [CNT_W-1:0] load_count(input logic [CFG_W-1:0] v);
    logic [CFG_W+CNT_W-1:0] wide;
    logic [CNT_W-1:0] res;
    wide = (CFG_W+CNT_W)'(v);
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (wide > (CFG_W+CNT_W)'(CNT_MAX)) begin
      res = CNT_MAX;
    end else begin
      res = wide[CNT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic cur_bit(input logic [BYTE_W-1:0] sb, input logic msb);
    return msb ? sb[BYTE_W-1] : sb[0];
  endfunction

endpackage

### rtl/als_step.sv
// line timing state and single-tick update for the LED serializer
// depends on als_pkg
module als_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      offer,
  input  logic [als_pkg::BYTE_W-1:0] pixel_byte,
  input  logic                      frame_end,
  input  als_pkg::timing_cfg_t      cfg,
  output als_pkg::tick_res_t        res
);

  als_pkg::phase_t              phase_r, phase_nxt;
  logic [als_pkg::CNT_W-1:0]    ticks_r, ticks_nxt;
  logic [als_pkg::BYTE_W-1:0]   shift_r, shift_nxt;
  logic [als_pkg::BITS_W-1:0]   bits_r, bits_nxt;
  logic                         latch_r, latch_nxt;
  logic                         taken;

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    latch_nxt = latch_r;
    taken     = 1'b0;

    if (phase_nxt == als_pkg::PH_IDLE && offer) begin
      taken     = 1'b1;
      shift_nxt = pixel_byte;
      bits_nxt  = als_pkg::BITS_PER_BYTE;
      latch_nxt = frame_end;
      phase_nxt = als_pkg::PH_HIGH;
      ticks_nxt = als_pkg::load_count(als_pkg::cur_bit(shift_nxt, cfg.msb_first) ?
                                      cfg.one_high : cfg.zero_high);
    end

    res.line_level = (phase_nxt == als_pkg::PH_HIGH);
    res.byte_taken = taken;
    res.busy_res   = (phase_nxt != als_pkg::PH_IDLE);

    if (phase_nxt != als_pkg::PH_IDLE) begin
      if (ticks_nxt != '0) begin
        ticks_nxt = ticks_nxt - als_pkg::CNT_W'(1);
      end
      if (ticks_nxt == '0) begin
        case (phase_nxt)
          als_pkg::PH_HIGH: begin
            phase_nxt = als_pkg::PH_LOW;
            ticks_nxt = als_pkg::load_count(als_pkg::cur_bit(shift_nxt, cfg.msb_first) ?
                                            cfg.one_low : cfg.zero_low);
          end
          als_pkg::PH_LOW: begin
            shift_nxt = cfg.msb_first ? {shift_nxt[als_pkg::BYTE_W-2:0], 1'b0}
                                      : {1'b0, shift_nxt[als_pkg::BYTE_W-1:1]};
            if (bits_nxt != '0) begin
              bits_nxt = bits_nxt - als_pkg::BITS_W'(1);
            end
            if (bits_nxt != '0) begin
              phase_nxt = als_pkg::PH_HIGH;
              ticks_nxt = als_pkg::load_count(als_pkg::cur_bit(shift_nxt, cfg.msb_first) ?
                                              cfg.one_high : cfg.zero_high);
            end else if (latch_nxt) begin
              latch_nxt = 1'b0;
              phase_nxt = als_pkg::PH_LATCH;
              ticks_nxt = als_pkg::load_count(cfg.latch);
            end else begin
              phase_nxt = als_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = als_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= als_pkg::PH_IDLE;
      ticks_r <= '0;
      shift_r <= '0;
      bits_r  <= '0;
      latch_r <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

### rtl/addressable_led_serializer.sv
// top level of the single-wire addressable LED serializer
// holds the config registers and word registers; depends on als_pkg and als_step
//
// Each input word is one tick of line timing and gives exactly one output word
// (line level, byte taken, busy). A new word is accepted every cycle unless the
// output side stalls; a word passes an input register and then an output
// register, which presents its result. Throughput is one word per cycle, set by
// the single-tick state update in als_step, when the output is not stalled. Config
// writes take effect at once and are meant for idle periods.
module addressable_led_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_offer,
  input  logic [als_pkg::BYTE_W-1:0]  in_pixel_byte,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_line_level,
  output logic                        out_byte_taken,
  output logic                        out_busy_res,
  input  logic                        cfg_wr_en,
  input  logic [als_pkg::IDX_W-1:0]   cfg_index,
  input  logic [als_pkg::CFG_W-1:0]   cfg_wdata
);

  als_pkg::timing_cfg_t       cfg_r;
  logic                       in_v_r;
  logic                       offer_r;
  logic [als_pkg::BYTE_W-1:0] byte_r;
  logic                       fend_r;
  logic                       out_v_r;
  als_pkg::tick_res_t         res_r;
  als_pkg::tick_res_t         res;
  logic                       advance;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high <= als_pkg::ZERO_HIGH_RST;
      cfg_r.zero_low  <= als_pkg::ZERO_LOW_RST;
      cfg_r.one_high  <= als_pkg::ONE_HIGH_RST;
      cfg_r.one_low   <= als_pkg::ONE_LOW_RST;
      cfg_r.latch     <= als_pkg::LATCH_RST;
      cfg_r.msb_first <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        als_pkg::REG_ZERO_HIGH: cfg_r.zero_high <= cfg_wdata;
        als_pkg::REG_ZERO_LOW:  cfg_r.zero_low  <= cfg_wdata;
        als_pkg::REG_ONE_HIGH:  cfg_r.one_high  <= cfg_wdata;
        als_pkg::REG_ONE_LOW:   cfg_r.one_low   <= cfg_wdata;
        als_pkg::REG_LATCH:     cfg_r.latch     <= cfg_wdata;
        als_pkg::REG_MSB_FIRST: cfg_r.msb_first <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      offer_r <= in_offer;
      byte_r  <= in_pixel_byte;
      fend_r  <= in_frame_end;
    end
  end

  als_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .offer      (offer_r),
    .pixel_byte (byte_r),
    .frame_end  (fend_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_line_level = res_r.line_level;
  assign out_byte_taken = res_r.byte_taken;
  assign out_busy_res   = res_r.busy_res;

endmodule
